FILE: hw/rtl/imhpq_pkg.sv
// ----------------------------------------------------------------------------
// imhpq_pkg: shared types and constants of the indexed min-heap queue
// Command and status codes and the widths of positions, ids and keys.
// ----------------------------------------------------------------------------
`default_nettype none
package imhpq_pkg;
  localparam int unsigned Capacity = 256;
  localparam int unsigned PosBits  = 9;  // positions 0..Capacity
  localparam int unsigned IdBits   = 8;
  localparam int unsigned KeyBits  = 32;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_DEL_MIN  = 2'd1,
    CMD_PEEK     = 2'd2,
    CMD_DEC_KEY  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_PRESENT   = 3'd4,
    ST_NOT_LESS  = 3'd5
  } status_e;
endpackage
`default_nettype wire

FILE: hw/rtl/imhpq_ram.sv
// ----------------------------------------------------------------------------
// imhpq_ram: single-port RAM with registered read
// One write or one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module imhpq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrBits = 8
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] addr_i,
  input  wire logic [Width-1:0]    wdata_i,
  output      logic [Width-1:0]    rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/indexed_min_heap_priority_queue_top.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_priority_queue_top: indexed binary min-heap
// Insert, delete-min, peek and decrease-key over 256 (id, key) entries.
// ----------------------------------------------------------------------------
// Peek and every error end after the checks; a decrease-key whose key is not
// smaller ends after the compare. Insert and decrease-key climb level by
// level; delete-min moves the last entry to the root unless it empties the
// heap, then descends level by level. At most 8 levels are crossed. The
// single-port heap and position memories set the pace: every read and swap
// write goes through one port each. Busy stays high from start until done;
// one request is handled at a time. Reset clears the count and all presence
// bits at once; no clearing pass is needed. The receiver cannot stall; done
// is one cycle.
`default_nettype none
module indexed_min_heap_priority_queue_top
  import imhpq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output      logic        busy_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  item_id_i,
  input  wire logic [31:0] key_i,
  output      logic        done_o,
  output      logic [7:0]  front_id_o,
  output      logic [31:0] front_key_o,
  output      logic [2:0]  status_o,
  output      logic [8:0]  entry_count_o,
  output      logic        is_empty_o
);

  // Sequencer states. Heap slot memory holds {id,key} packed.
  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_CHECK  = 16'h0002, // position map read returned, decide
    S_RDROOT = 16'h0004, // reading root (slot 1)
    S_ROOTW  = 16'h0008, // root data back, or the entry at pos for decrease-key
    S_RDLAST = 16'h0010, // reading last slot for delete
    S_LASTW  = 16'h0020, // write last into root
    S_UPRD   = 16'h0040, // read parent
    S_UPCMP  = 16'h0080, // compare with parent
    S_UPW2   = 16'h0100, // write second half of swap
    S_DNRD1  = 16'h0200, // read left child
    S_DNRD2  = 16'h0400, // read right child
    S_DNCMP  = 16'h0800, // compare with the smaller child
    S_DNW2   = 16'h1000, // second swap write
    S_PMAP   = 16'h2000, // right child back, keep the smaller child
    S_FIN    = 16'h4000, // read root for the report
    S_OUT    = 16'h8000
  } state_e;

  localparam int unsigned SlotBits = IdBits + KeyBits;

  state_e state_q, state_d;
  logic [PosBits-1:0] count_q, count_d;
  logic [Capacity-1:0] present_q, present_d;
  cmd_e cmd_q, cmd_d;
  logic [IdBits-1:0] id_q, id_d;
  logic [KeyBits-1:0] key_q, key_d;
  logic [PosBits-1:0] pos_q, pos_d;      // position of the moving entry
  logic [PosBits-1:0] oth_q, oth_d;      // partner slot
  logic [SlotBits-1:0] cur_q, cur_d;     // moving entry {id,key}
  logic [SlotBits-1:0] oth_slot_q, oth_slot_d;
  logic [SlotBits-1:0] left_q, left_d;
  logic [2:0] stat_q, stat_d;
  logic took_q, took_d;
  logic [SlotBits-1:0] took_slot_q, took_slot_d;

  // Slot memory port
  logic                 h_we;
  logic [PosBits-1:0]   h_addr;
  logic [SlotBits-1:0]  h_wdata, h_rdata;
  // Position map port
  logic                 p_we;
  logic [IdBits-1:0]    p_addr;
  logic [PosBits-1:0]   p_wdata, p_rdata;

  imhpq_ram #(.Width(SlotBits), .Depth(Capacity + 1), .AddrBits(PosBits)) u_heap (
    .clk_i, .we_i(h_we), .addr_i(h_addr), .wdata_i(h_wdata), .rdata_o(h_rdata)
  );
  imhpq_ram #(.Width(PosBits), .Depth(Capacity), .AddrBits(IdBits)) u_pmap (
    .clk_i, .we_i(p_we), .addr_i(p_addr), .wdata_i(p_wdata), .rdata_o(p_rdata)
  );

  // The shared unit: one key comparator for every sift decision.
  logic [KeyBits-1:0] cmp_a, cmp_b;
  logic cmp_gt;
  assign cmp_gt = cmp_a > cmp_b;

  logic [PosBits-1:0] child_l;
  assign child_l = {pos_q[PosBits-2:0], 1'b0};

  always_comb begin
    state_d = state_q; count_d = count_q; present_d = present_q;
    cmd_d = cmd_q; id_d = id_q; key_d = key_q; pos_d = pos_q; oth_d = oth_q;
    cur_d = cur_q; oth_slot_d = oth_slot_q; left_d = left_q; stat_d = stat_q;
    took_d = took_q; took_slot_d = took_slot_q;
    h_we = 1'b0; h_addr = '0; h_wdata = cur_q;
    p_we = 1'b0; p_addr = cur_q[SlotBits-1:KeyBits]; p_wdata = pos_q;
    cmp_a = oth_slot_q[KeyBits-1:0]; cmp_b = cur_q[KeyBits-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_e'(command_i); id_d = item_id_i; key_d = key_i;
          stat_d = ST_OK; took_d = 1'b0;
          p_addr = item_id_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_FIN;
        case (cmd_q)
          CMD_INSERT: begin
            if (count_q == PosBits'(Capacity)) stat_d = ST_FULL;
            else if (present_q[id_q]) stat_d = ST_PRESENT;
            else begin
              count_d = count_q + 1'b1;
              present_d[id_q] = 1'b1;
              pos_d = count_q + 1'b1;
              cur_d = {id_q, key_q};
              h_we = 1'b1; h_addr = count_q + 1'b1; h_wdata = {id_q, key_q};
              state_d = S_UPRD;
            end
          end
          CMD_DEL_MIN: begin
            if (count_q == '0) stat_d = ST_EMPTY;
            else state_d = S_RDROOT;
          end
          CMD_PEEK: begin
            if (count_q == '0) stat_d = ST_EMPTY;
          end
          default: begin
            if (!present_q[id_q]) stat_d = ST_ABSENT;
            else begin
              pos_d = p_rdata;
              h_addr = p_rdata;
              oth_d = p_rdata;
              state_d = S_ROOTW;
            end
          end
        endcase
      end
      S_RDROOT: begin
        h_addr = PosBits'(1);
        state_d = S_ROOTW;
      end
      S_ROOTW: begin
        if (cmd_q == CMD_DEL_MIN) begin
          took_d = 1'b1; took_slot_d = h_rdata;
          present_d[h_rdata[SlotBits-1:KeyBits]] = 1'b0;
          state_d = S_RDLAST;
        end else begin
          // decrease key: h_rdata is the entry at pos
          cmp_a = h_rdata[KeyBits-1:0]; cmp_b = key_q;
          if (!cmp_gt) begin
            stat_d = ST_NOT_LESS; state_d = S_FIN;
          end else begin
            cur_d = {id_q, key_q};
            h_we = 1'b1; h_addr = pos_q; h_wdata = {id_q, key_q};
            state_d = S_UPRD;
          end
        end
      end
      S_RDLAST: begin
        h_addr = count_q;
        count_d = count_q - 1'b1;
        state_d = S_LASTW;
      end
      S_LASTW: begin
        if (count_q == '0) state_d = S_FIN;
        else begin
          cur_d = h_rdata; pos_d = PosBits'(1);
          h_we = 1'b1; h_addr = PosBits'(1); h_wdata = h_rdata;
          p_we = 1'b1; p_addr = h_rdata[SlotBits-1:KeyBits]; p_wdata = PosBits'(1);
          state_d = S_DNRD1;
        end
      end
      S_UPRD: begin
        // Map write for the moving entry at its current place, parent read.
        p_we = 1'b1; p_addr = cur_q[SlotBits-1:KeyBits]; p_wdata = pos_q;
        if (pos_q <= PosBits'(1)) state_d = S_FIN;
        else begin
          oth_d = pos_q >> 1;
          h_addr = pos_q >> 1;
          state_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        cmp_a = h_rdata[KeyBits-1:0]; cmp_b = cur_q[KeyBits-1:0];
        if (!cmp_gt) state_d = S_FIN;
        else begin
          oth_slot_d = h_rdata;
          h_we = 1'b1; h_addr = pos_q; h_wdata = h_rdata;
          state_d = S_UPW2;
        end
      end
      S_UPW2: begin
        h_we = 1'b1; h_addr = oth_q; h_wdata = cur_q;
        p_we = 1'b1; p_addr = oth_slot_q[SlotBits-1:KeyBits]; p_wdata = pos_q;
        pos_d = oth_q;
        state_d = S_UPRD;
      end
      S_DNRD1: begin
        if (child_l > count_q) state_d = S_FIN;
        else begin
          h_addr = child_l;
          state_d = S_DNRD2;
        end
      end
      S_DNRD2: begin
        left_d = h_rdata; oth_slot_d = h_rdata; oth_d = child_l;
        if (child_l < count_q) begin
          h_addr = child_l + 1'b1;
          state_d = S_PMAP;   // right child read, pick in S_PMAP
        end else state_d = S_DNCMP;
      end
      S_PMAP: begin
        cmp_a = left_q[KeyBits-1:0]; cmp_b = h_rdata[KeyBits-1:0];
        if (cmp_gt) begin
          oth_slot_d = h_rdata; oth_d = child_l + 1'b1;
        end
        state_d = S_DNCMP;
      end
      S_DNCMP: begin
        cmp_a = cur_q[KeyBits-1:0]; cmp_b = oth_slot_q[KeyBits-1:0];
        if (!cmp_gt) state_d = S_FIN;
        else begin
          h_we = 1'b1; h_addr = pos_q; h_wdata = oth_slot_q;
          p_we = 1'b1; p_addr = oth_slot_q[SlotBits-1:KeyBits]; p_wdata = pos_q;
          state_d = S_DNW2;
        end
      end
      S_DNW2: begin
        h_we = 1'b1; h_addr = oth_q; h_wdata = cur_q;
        p_we = 1'b1; p_addr = cur_q[SlotBits-1:KeyBits]; p_wdata = oth_q;
        pos_d = oth_q;
        state_d = S_DNRD1;
      end
      S_FIN: begin
        h_addr = PosBits'(1);
        state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; present_q <= '0;
      took_q <= 1'b0; stat_q <= ST_OK;
    end else begin
      state_q <= state_d; count_q <= count_d; present_q <= present_d;
      took_q <= took_d; stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; id_q <= id_d; key_q <= key_d; pos_q <= pos_d; oth_q <= oth_d;
    cur_q <= cur_d; oth_slot_q <= oth_slot_d; left_q <= left_d;
    took_slot_q <= took_slot_d;
  end

  // The report: removed entry, else the root when the heap is not empty.
  logic [SlotBits-1:0] front;
  always_comb begin
    if (took_q) front = took_slot_q;
    else if (count_q != '0) front = h_rdata;
    else front = '0;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = (state_q == S_OUT);
  assign front_id_o    = front[SlotBits-1:KeyBits];
  assign front_key_o   = front[KeyBits-1:0];
  assign status_o      = stat_q;
  assign entry_count_o = count_q;
  assign is_empty_o    = (count_q == '0);
endmodule
`default_nettype wire
